>>> src/nir_pkg.sv
// shared types and constants of the nec ir frame encoder
package nir_pkg;

   localparam int DUR_W     = 16;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 3;
   localparam int SEG_CNT_W = 6;

   // request codes
   localparam logic OP_FRAME  = 1'b0;
   localparam logic OP_REPEAT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_MARK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SPACE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_CHECK = 3'd5;

   // register reset values
   localparam logic [DUR_W-1:0]  RST_HEADER_MARK   = 16'd1630;
   localparam logic [DUR_W-1:0]  RST_HEADER_SPACE  = 16'd818;
   localparam logic [DUR_W-1:0]  RST_SHORT         = 16'd102;
   localparam logic [DUR_W-1:0]  RST_LONG          = 16'd280;
   localparam logic [BYTE_W-1:0] RST_ADDRESS       = 8'h01;
   localparam logic [BYTE_W-1:0] RST_ADDRESS_CHECK = 8'hFE;

   // index of the last segment of each request, header at index 0
   localparam logic [SEG_CNT_W-1:0] FRAME_LAST_SEG  = 6'd33;
   localparam logic [SEG_CNT_W-1:0] REPEAT_LAST_SEG = 6'd1;

   // byte slots of a full frame
   localparam logic [1:0] SLOT_ADDRESS       = 2'd0;
   localparam logic [1:0] SLOT_ADDRESS_CHECK = 2'd1;
   localparam logic [1:0] SLOT_COMMAND       = 2'd2;
   localparam logic [1:0] SLOT_COMMAND_INV   = 2'd3;

   typedef struct packed {
      logic [DUR_W-1:0]  header_mark_len;
      logic [DUR_W-1:0]  header_space_len;
      logic [DUR_W-1:0]  short_len;
      logic [DUR_W-1:0]  long_len;
      logic [BYTE_W-1:0] address_byte;
      logic [BYTE_W-1:0] address_check_byte;
   } cfg_type;

   typedef struct packed {
      logic              is_repeat;
      logic [BYTE_W-1:0] command;
   } req_entry_type;

   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } queue_head_type;

endpackage

>>> src/nec_ir_frame_encoder.sv
// top level of the nec ir frame encoder: register file, intake queue and sequencer
//
// Each request turns into mark/space segment pairs in delay units: a full frame
// (op 0) gives 34 pairs (header, address, address check, command, inverted
// command, each byte lsb first, then a stop pair), a repeat code (op 1) gives 2
// pairs. The final pair of a request has rsp_last set. The sequencer produces one
// pair per cycle while rsp_pop keeps taking results, and consecutive requests
// follow with no gap. A request queue of QUEUE_DEPTH entries in front of the
// sequencer lets new requests be taken while one is still being sent; a single
// result register holds each pair until rsp_pop takes it, and the sequencer
// stalls while a pair waits there. The six timing and address registers are
// written over the csr port, always ready; writes to unused indexes are dropped.
// Registers must only be changed while no request is in flight.
module nec_ir_frame_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // request transfer
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_op,
   input  logic [nir_pkg::BYTE_W-1:0]      req_command,
   // segment transfer
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [nir_pkg::DUR_W-1:0]       rsp_mark_len,
   output logic [nir_pkg::DUR_W-1:0]       rsp_space_len,
   output logic                            rsp_last,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nir_pkg::DUR_W-1:0]       csr_data
);
   import nir_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           head_pop;
   logic           csr_write;

   // register file never stalls a write
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_HEADER_MARK:   cfg_in.header_mark_len    = csr_data;
            CSR_HEADER_SPACE:  cfg_in.header_space_len   = csr_data;
            CSR_SHORT:         cfg_in.short_len          = csr_data;
            CSR_LONG:          cfg_in.long_len           = csr_data;
            CSR_ADDRESS:       cfg_in.address_byte       = csr_data[BYTE_W-1:0];
            CSR_ADDRESS_CHECK: cfg_in.address_check_byte = csr_data[BYTE_W-1:0];
            default:           cfg_in = cfg_ff;   // unused index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark_len    <= RST_HEADER_MARK;
         cfg_ff.header_space_len   <= RST_HEADER_SPACE;
         cfg_ff.short_len          <= RST_SHORT;
         cfg_ff.long_len           <= RST_LONG;
         cfg_ff.address_byte       <= RST_ADDRESS;
         cfg_ff.address_check_byte <= RST_ADDRESS_CHECK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // intake: classify and queue requests
   nir_front #(
      .DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_op      (req_op),
      .req_command (req_command),
      .head_pop    (head_pop),
      .head        (head)
   );

   // sequencer: one segment pair per cycle into the result register while it is free or being popped
   nir_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head          (head),
      .head_pop      (head_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_mark_len  (rsp_mark_len),
      .rsp_space_len (rsp_space_len),
      .rsp_last      (rsp_last)
   );

endmodule

>>> src/nir_front.sv
// request intake: classifies requests and queues them for the sequencer
module nir_front #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_op,
   input  logic [nir_pkg::BYTE_W-1:0]   req_command,
   input  logic                         head_pop,
   output nir_pkg::queue_head_type      head
);
   import nir_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   req_entry_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;
   req_entry_type    new_entry;

   assign req_full = (count_ff == CNT_W'(DEPTH));
   assign do_push  = req_push && !req_full;
   assign do_pop   = head_pop && (count_ff != '0);

   always_comb begin
      new_entry.is_repeat = (req_op == OP_REPEAT);
      new_entry.command   = req_command;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

   always_comb begin
      head.valid = (count_ff != '0);
      head.entry = entry_ff[rd_ptr_ff];
   end

endmodule

>>> src/nir_back.sv
// segment sequencer with registered result stage
module nir_back (
   input  logic                         clock,
   input  logic                         reset,
   input  nir_pkg::cfg_type             cfg,
   input  nir_pkg::queue_head_type      head,
   output logic                         head_pop,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [nir_pkg::DUR_W-1:0]    rsp_mark_len,
   output logic [nir_pkg::DUR_W-1:0]    rsp_space_len,
   output logic                         rsp_last
);
   import nir_pkg::*;

   logic [SEG_CNT_W-1:0] seg_cnt_ff, seg_cnt_in;
   logic                 out_valid_ff;
   logic [DUR_W-1:0]     mark_ff, mark_in;
   logic [DUR_W-1:0]     space_ff, space_in;
   logic                 last_ff, last_in;
   logic                 advance, load;
   logic [SEG_CNT_W-2:0] bit_pos;
   logic [BYTE_W-1:0]    cur_byte;
   logic                 cur_bit;

   assign advance = !out_valid_ff || rsp_pop;
   assign load    = advance && head.valid;

   // data bit pairs sit at segments 1 to 32
   assign bit_pos = (SEG_CNT_W-1)'(seg_cnt_ff - 1'b1);

   always_comb begin
      unique case (bit_pos[4:3])
         SLOT_ADDRESS:       cur_byte = cfg.address_byte;
         SLOT_ADDRESS_CHECK: cur_byte = cfg.address_check_byte;
         SLOT_COMMAND:       cur_byte = head.entry.command;
         SLOT_COMMAND_INV:   cur_byte = ~head.entry.command;
         default:            cur_byte = head.entry.command;
      endcase
      cur_bit = cur_byte[bit_pos[2:0]];
   end

   always_comb begin
      mark_in  = cfg.short_len;
      space_in = cur_bit ? cfg.long_len : cfg.short_len;
      last_in  = 1'b0;
      if (seg_cnt_ff == '0) begin
         mark_in  = cfg.header_mark_len;
         space_in = head.entry.is_repeat ? cfg.long_len : cfg.header_space_len;
      end else if (head.entry.is_repeat) begin
         // repeat code tail: short mark, line left idle high
         space_in = '0;
         last_in  = 1'b1;
      end else if (seg_cnt_ff == FRAME_LAST_SEG) begin
         // stop pair
         space_in = cfg.short_len;
         last_in  = 1'b1;
      end
   end

   assign head_pop   = load && last_in;
   assign seg_cnt_in = head_pop ? '0 : seg_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            seg_cnt_ff <= seg_cnt_in;
         end
         if (advance) begin
            out_valid_ff <= head.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mark_ff  <= mark_in;
         space_ff <= space_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_mark_len  = mark_ff;
   assign rsp_space_len = space_ff;
   assign rsp_last      = last_ff;

endmodule

>>> src/nir_checker.sv
// port-level checks of the nec ir frame encoder and their binding
module nir_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_full,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [nir_pkg::DUR_W-1:0]     rsp_mark_len,
   input logic [nir_pkg::DUR_W-1:0]     rsp_space_len,
   input logic                          rsp_last
);
   import nir_pkg::*;

   // nothing waits on the result side right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // request queue starts with room
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request queue full after reset");

   // within a request, pairs follow one another without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last) |=> !rsp_empty)
      else $error("gap inside a request");

   // a waiting result holds still
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_mark_len)
         && $stable(rsp_space_len) && $stable(rsp_last)))
      else $error("waiting result changed");

endmodule

bind nec_ir_frame_encoder nir_checker u_nir_checker (
   .clock         (clock),
   .reset         (reset),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_mark_len  (rsp_mark_len),
   .rsp_space_len (rsp_space_len),
   .rsp_last      (rsp_last)
);

>>> tb/tb_nec_ir_frame_encoder.sv
// testbench of the nec ir frame encoder: segment prediction and in-order checking
`timescale 1ns / 100ps

module tb_nec_ir_frame_encoder;
   import nir_pkg::*;

   // cycles without any transfer before the run is declared hung; the longest
   // legal quiet stretch is the receiver hold-off plus a few idle gaps
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_ITEMS = 130;

   // indexes past the register file, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [DUR_W-1:0] mark_len;
      logic [DUR_W-1:0] space_len;
      logic             last;
   } segment_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic                 req_op = OP_FRAME;
   logic [BYTE_W-1:0]    req_command = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [DUR_W-1:0]     rsp_mark_len;
   logic [DUR_W-1:0]     rsp_space_len;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DUR_W-1:0]     csr_data = '0;

   // our own copy of the register file and the segments still owed by the block
   cfg_type     shadow_cfg;
   segment_type pending_segments[$];

   int error_count = 0;
   int stall_cycles = 0;
   // idle_enable off gives stretches where both sides run flat out
   bit idle_enable = 1'b1;
   int hold_off_request = 0;

   nec_ir_frame_encoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_command   (req_command),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_mark_len  (rsp_mark_len),
      .rsp_space_len (rsp_space_len),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // segment prediction
   // ---------------------------------------------------------------------------

   function automatic void owe_pair(logic [DUR_W-1:0] mark, logic [DUR_W-1:0] space,
                                    logic last);
      segment_type seg;
      seg.mark_len = mark;
      seg.space_len = space;
      seg.last = last;
      pending_segments.push_back(seg);
   endfunction

   // one request -> header pair, 32 bit pairs lsb first, stop pair;
   // a repeat code is header mark + long space, then a bare short mark
   function automatic void predict_segments(logic op, logic [BYTE_W-1:0] command);
      logic [BYTE_W-1:0] frame_bytes [4];
      if (op == OP_REPEAT) begin
         owe_pair(shadow_cfg.header_mark_len, shadow_cfg.long_len, 1'b0);
         owe_pair(shadow_cfg.short_len, '0, 1'b1);
         return;
      end
      owe_pair(shadow_cfg.header_mark_len, shadow_cfg.header_space_len, 1'b0);
      frame_bytes[SLOT_ADDRESS] = shadow_cfg.address_byte;
      frame_bytes[SLOT_ADDRESS_CHECK] = shadow_cfg.address_check_byte;
      frame_bytes[SLOT_COMMAND] = command;
      frame_bytes[SLOT_COMMAND_INV] = ~command;
      for (int slot = 0; slot < 4; slot++) begin
         for (int b = 0; b < BYTE_W; b++) begin
            owe_pair(shadow_cfg.short_len,
                     frame_bytes[slot][b] ? shadow_cfg.long_len : shadow_cfg.short_len, 1'b0);
         end
      end
      // stop pair: short mark, short space
      owe_pair(shadow_cfg.short_len, shadow_cfg.short_len, 1'b1);
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // offers one request after a random gap; push is left high on return so that
   // back-to-back requests never lower and raise it within one time step
   task automatic send_request(logic op, logic [BYTE_W-1:0] command);
      int gap;
      gap = idle_enable ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_command <= command;
      // full is sampled before the edge updates it, so this is the value the block saw
      do @(posedge clock); while (req_full);
      predict_segments(op, command);
   endtask

   // stop offering and let every owed segment drain; each request produces
   // segments, so an empty store means the block has gone quiet
   task automatic wait_idle();
      if (req_push) req_push <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // register writes, only issued while the block is idle
   // ---------------------------------------------------------------------------

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [DUR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_HEADER_MARK:   shadow_cfg.header_mark_len = data;
         CSR_HEADER_SPACE:  shadow_cfg.header_space_len = data;
         CSR_SHORT:         shadow_cfg.short_len = data;
         CSR_LONG:          shadow_cfg.long_len = data;
         CSR_ADDRESS:       shadow_cfg.address_byte = data[BYTE_W-1:0];
         CSR_ADDRESS_CHECK: shadow_cfg.address_check_byte = data[BYTE_W-1:0];
         default: ;
      endcase
   endtask

   // byte registers get random upper bits, which the block must drop
   task automatic program_regs(cfg_type cfg, bit with_unused);
      write_csr(CSR_HEADER_MARK, cfg.header_mark_len);
      write_csr(CSR_HEADER_SPACE, cfg.header_space_len);
      write_csr(CSR_SHORT, cfg.short_len);
      write_csr(CSR_LONG, cfg.long_len);
      write_csr(CSR_ADDRESS, {8'($urandom), cfg.address_byte});
      write_csr(CSR_ADDRESS_CHECK, {8'($urandom), cfg.address_check_byte});
      if (with_unused) begin
         write_csr(CSR_UNUSED_LO, 16'($urandom));
         write_csr(CSR_UNUSED_HI, 16'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DUR_W-1:0] pick_duration();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return DUR_W'($urandom);
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type cfg;
      cfg.header_mark_len = pick_duration();
      cfg.header_space_len = pick_duration();
      cfg.short_len = pick_duration();
      cfg.long_len = pick_duration();
      cfg.address_byte = BYTE_W'($urandom);
      cfg.address_check_byte = BYTE_W'($urandom);
      return cfg;
   endfunction

   // ---------------------------------------------------------------------------
   // result side: pop pacing and in-order checking
   // ---------------------------------------------------------------------------

   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request != 0) begin
            // long hold-off so the intake queue fills and full goes up
            gap = hold_off_request;
            hold_off_request = 0;
         end else begin
            gap = idle_enable ? $urandom_range(0, 9) : 0;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_segments.size() == 0) begin
            $error("segment with none owed: mark_len %0d space_len %0d last %0b",
                   rsp_mark_len, rsp_space_len, rsp_last);
            error_count++;
         end else begin
            want = pending_segments.pop_front();
            if (rsp_mark_len !== want.mark_len) begin
               $error("mark_len: expected %0d, got %0d", want.mark_len, rsp_mark_len);
               error_count++;
            end
            if (rsp_space_len !== want.space_len) begin
               $error("space_len: expected %0d, got %0d", want.space_len, rsp_space_len);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // watchdog: any transfer on any channel restarts the count
   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
             || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("nec_ir_frame_encoder: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // register values straight out of reset, command extremes and a repeat
   task automatic test_reset_values();
      send_request(OP_FRAME, 8'h00);
      send_request(OP_FRAME, 8'hFF);
      send_request(OP_REPEAT, 8'h00);
      wait_idle();
   endtask

   // alternating bit patterns and single bits; the repeat command must not matter
   task automatic test_commands();
      send_request(OP_FRAME, 8'h55);
      send_request(OP_FRAME, 8'hAA);
      send_request(OP_FRAME, 8'h01);
      send_request(OP_FRAME, 8'h80);
      send_request(OP_REPEAT, 8'hFF);
      send_request(OP_REPEAT, 8'hA5);
      send_request(OP_FRAME, 8'h3C);
      wait_idle();
   endtask

   // all-zero durations pass through, then all-ones, then a spread-out setting;
   // writes to unused indexes go along each time and must change nothing
   task automatic test_register_extremes();
      cfg_type cfg;
      cfg = '0;
      program_regs(cfg, 1'b1);
      send_request(OP_FRAME, 8'hC3);
      send_request(OP_REPEAT, 8'h00);
      wait_idle();
      cfg = '1;
      program_regs(cfg, 1'b1);
      send_request(OP_FRAME, 8'h0F);
      send_request(OP_REPEAT, 8'h5A);
      wait_idle();
      cfg.header_mark_len = 16'd9000;
      cfg.header_space_len = 16'd4500;
      cfg.short_len = 16'd560;
      cfg.long_len = 16'd1690;
      cfg.address_byte = 8'h80;
      cfg.address_check_byte = 8'h7F;
      program_regs(cfg, 1'b1);
      send_request(OP_FRAME, 8'hE7);
      wait_idle();
   endtask

   // receiver stops for a long stretch while requests keep coming in
   task automatic test_backpressure();
      idle_enable = 1'b0;
      hold_off_request = HOLD_OFF_CYCLES;
      for (int i = 0; i < 8; i++)
         send_request((i % 3 == 2) ? OP_REPEAT : OP_FRAME, BYTE_W'($urandom));
      wait_idle();
      idle_enable = 1'b1;
   endtask

   // phases of random requests, each under a fresh random register setting
   task automatic test_random_requests(int item_total);
      int sent;
      int phase_len;
      sent = 0;
      while (sent < item_total) begin
         wait_idle();
         program_regs(random_cfg(), 1'($urandom_range(0, 1)));
         idle_enable = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(15, 35);
         for (int i = 0; i < phase_len && sent < item_total; i++) begin
            // mostly full frames, which exercise the whole sequencer
            send_request(($urandom_range(0, 3) == 0) ? OP_REPEAT : OP_FRAME,
                         BYTE_W'($urandom));
            sent++;
         end
      end
      wait_idle();
      idle_enable = 1'b1;
   endtask

   initial begin
      shadow_cfg.header_mark_len = RST_HEADER_MARK;
      shadow_cfg.header_space_len = RST_HEADER_SPACE;
      shadow_cfg.short_len = RST_SHORT;
      shadow_cfg.long_len = RST_LONG;
      shadow_cfg.address_byte = RST_ADDRESS;
      shadow_cfg.address_check_byte = RST_ADDRESS_CHECK;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_commands();
      test_register_extremes();
      test_backpressure();
      test_random_requests(RANDOM_ITEMS);

      // settle, then report
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_segments.size() == 0)
         $display("nec_ir_frame_encoder: match");
      else
         $display("nec_ir_frame_encoder: mismatch");
      $finish;
   end

endmodule

>>> files.f
src/nir_pkg.sv
src/nir_front.sv
src/nir_back.sv
src/nec_ir_frame_encoder.sv
src/nir_checker.sv
tb/tb_nec_ir_frame_encoder.sv
